// ===== sv/ssruc_pkg.sv =====
// Shared constants and types for the sorted set range union count block.
package ssruc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ENTRY_W     = $clog2(MAX_ENTRIES + 1);
    localparam int COUNT_W     = 11;
    localparam int VALUE_W     = 32;

    // Word kinds carried on tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Both closed query intervals.
    typedef struct packed {
        logic signed [VALUE_W-1:0] first_low;
        logic signed [VALUE_W-1:0] first_high;
        logic signed [VALUE_W-1:0] second_low;
        logic signed [VALUE_W-1:0] second_high;
    } bounds_t;

    // Strobes broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;   // shift right from the insertion point, drop value in
        logic capture;  // latch membership bit for the query
        logic shift;    // move membership bits one cell toward the head
    } cell_ctrl_t;

endpackage

// ===== sv/sorted_set_range_union_count.sv =====
// A load is registered into the chain at its accept; a query's count is registered after the SCAN and DONE states.
// Throughput: one load per cycle while no query is busy; a query holds off input until its count is
// registered, a wait set by the membership bits leaving the chain head one per cycle, and longer while an
// earlier count still waits on m_tready.
// Reset (aresetn low, synchronous) clears every cell's valid flag, the entry count and the
// sequencer; stored values are not reset and are never read until written.
module sorted_set_range_union_count
    import ssruc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // [31:0] value, [63:32] first_low, [95:64] first_high,
                                    // [127:96] second_low, [159:128] second_high
    input  logic         s_tuser,   // [0] kind: 0 load, 1 query
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // [10:0] count
);

    logic               accept;
    logic               full;
    logic               busy;
    logic               shift;
    logic [ENTRY_W-1:0] entry_count_reg;
    cell_ctrl_t         ctrl;
    bounds_t            bounds;
    logic signed [VALUE_W-1:0] new_value;

    // Neighbor links along the chain.
    logic signed [VALUE_W-1:0] cell_value [MAX_ENTRIES];
    logic                      cell_gt    [MAX_ENTRIES];
    logic                      cell_valid [MAX_ENTRIES];
    logic                      cell_hit   [MAX_ENTRIES];

    assign new_value          = s_tdata[31:0];
    assign bounds.first_low   = s_tdata[63:32];
    assign bounds.first_high  = s_tdata[95:64];
    assign bounds.second_low  = s_tdata[127:96];
    assign bounds.second_high = s_tdata[159:128];

    // No word is taken while a query scans or waits to deliver its count.
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign full     = (entry_count_reg == ENTRY_W'(MAX_ENTRIES));

    // Load into a full store is dropped.
    assign ctrl.insert  = accept && (s_tuser == KIND_LOAD) && !full;
    assign ctrl.capture = accept && (s_tuser == KIND_QUERY);
    assign ctrl.shift   = shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (ctrl.insert) begin
            entry_count_reg <= entry_count_reg + ENTRY_W'(1);
        end
    end

    // Values ride right on insert; membership bits ride left toward the head on a scan.
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_gt;
        logic                      left_valid;
        logic                      right_bit;

        if (i == 0) begin : g_head
            assign left_value = '0;
            assign left_gt    = 1'b0;
            assign left_valid = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_tail
            assign right_bit = 1'b0;
        end else begin : g_mid
            assign right_bit = cell_hit[i+1];
        end

        ssruc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_value  (new_value),
            .bounds     (bounds),
            .left_value (left_value),
            .left_gt    (left_gt),
            .left_valid (left_valid),
            .right_bit  (right_bit),
            .value      (cell_value[i]),
            .gt         (cell_gt[i]),
            .valid      (cell_valid[i]),
            .hit        (cell_hit[i])
        );
    end

    ssruc_tally u_tally (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (ctrl.capture),
        .entry_count (entry_count_reg),
        .head_bit    (cell_hit[0]),
        .shift       (shift),
        .busy        (busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // A query locks out the input on the next cycle.
    a_query_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.capture |=> !s_tready)
        else $error("input open right after query accept");

    // Valid cells form a prefix: head valid exactly when the store is not empty.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[0] == (entry_count_reg != '0))
        else $error("head cell valid disagrees with entry count");

    // Tail cell valid exactly when full.
    a_tail_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[MAX_ENTRIES-1] == full)
        else $error("tail cell valid disagrees with full");

    // A count never exceeds the stored entries.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ENTRY_W'(m_tdata[COUNT_W-1:0]) <= entry_count_reg))
        else $error("count above entry count");

endmodule

// ===== sv/ssruc_cell.sv =====
// One cell of the sorted chain: stored value, valid flag, membership bit.
module ssruc_cell
    import ssruc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] new_value,
    input  bounds_t                   bounds,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic                      left_gt,
    input  logic                      left_valid,
    input  logic                      right_bit,
    output logic signed [VALUE_W-1:0] value,
    output logic                      gt,
    output logic                      valid,
    output logic                      hit
);

    logic signed [VALUE_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      hit_reg;
    logic                      take;
    logic                      in_first;
    logic                      in_second;

    // Stored values ascend along the chain, so gt marks a suffix of valid cells.
    assign gt   = valid_reg && (value_reg > new_value);
    assign take = gt || (!valid_reg && left_valid);

    assign in_first  = (bounds.first_low <= value_reg)
                       && (value_reg <= bounds.first_high);
    assign in_second = (bounds.second_low <= value_reg)
                       && (value_reg <= bounds.second_high);

    always_ff @(posedge aclk) begin
        if (ctrl.insert && take) begin
            value_reg <= left_gt ? left_value : new_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctrl.insert) begin
                valid_reg <= valid_reg | left_valid;
            end
            if (ctrl.capture) begin
                hit_reg <= valid_reg && (in_first || in_second);
            end else if (ctrl.shift) begin
                hit_reg <= right_bit;
            end
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

// ===== sv/ssruc_tally.sv =====
// Query sequencer: shifts membership bits out of the chain head and counts them.
module ssruc_tally
    import ssruc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ENTRY_W-1:0] entry_count,
    input  logic               head_bit,
    output logic               shift,
    output logic               busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata   // [10:0] count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [ENTRY_W-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] result_reg, result_next;
    logic               out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !m_tready;
        shift          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    remain_next = entry_count;
                    total_next  = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (remain_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    total_next  = total_reg + COUNT_W'(head_bit);
                    remain_next = remain_reg - ENTRY_W'(1);
                    shift       = 1'b1;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    result_next    = total_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        remain_reg <= remain_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-COUNT_W){1'b0}}, result_reg};

endmodule
